@@ sv/pwb_pkg.sv @@
// shared constants, types and gain functions for the world-to-body transform
package pwb_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 32;
    localparam int ROT_W   = 36;
    localparam int INV_W   = 31;
    localparam int SPLIT_W = 18;
    localparam int PLO_W   = SPLIT_W + 1 + INV_W;
    localparam int PHI_W   = (ROT_W - SPLIT_W) + INV_W;
    localparam int ACC_W   = PHI_W + SPLIT_W + 1;
    localparam int FRAC_SH = 30;
    localparam int SCL_W   = ACC_W - FRAC_SH;

    localparam int PIPE_DEPTH = CORDIC_STAGES + 5;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(64'sd1 <<< 28);

    typedef struct packed {
        logic signed [ROT_W-1:0] c;
        logic signed [ROT_W-1:0] s;
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        logic                    bypass;
    } t_rot;

    // squared gain of the stage chain, q60
    function automatic logic [63:0] gain_sq_q60();
        logic [63:0] g2;
        g2 = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        return g2;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = v;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam logic [63:0] GAIN_Q30     = isqrt64(gain_sq_q60());
    localparam logic [63:0] INV_GAIN_Q30 = (64'd1 << 60) / GAIN_Q30;
    localparam logic signed [INV_W-1:0] INV_GAIN = INV_W'(INV_GAIN_Q30);

endpackage

@@ sv/pwb_prep.sv @@
// offset, yaw terms and half-plane fold ahead of the rotation chain
module pwb_prep import pwb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_robot_x,
    input  logic signed [COORD_W-1:0] i_robot_y,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_rot                      o_data
);

    logic                     r_v1;
    logic                     r_v2;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [PROD_W-1:0] r_wz;
    logic signed [PROD_W-1:0] r_xy;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_zz;
    t_rot                     r_data;
    t_rot                     n_data;
    logic                     en1;
    logic                     en2;

    logic signed [DIFF_W-1:0] s_half;
    logic signed [DIFF_W-1:0] q_half;
    logic signed [ROT_W-1:0]  s_full;
    logic signed [ROT_W-1:0]  c_full;
    logic signed [ROT_W-1:0]  dx_full;
    logic signed [ROT_W-1:0]  dy_full;
    logic                     zero;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_dx <= DIFF_W'(i_point_x) - DIFF_W'(i_robot_x);
            r_dy <= DIFF_W'(i_point_y) - DIFF_W'(i_robot_y);
            r_wz <= PROD_W'(i_quat_w) * PROD_W'(i_quat_z);
            r_xy <= PROD_W'(i_quat_x) * PROD_W'(i_quat_y);
            r_yy <= PROD_W'(i_quat_y) * PROD_W'(i_quat_y);
            r_zz <= PROD_W'(i_quat_z) * PROD_W'(i_quat_z);
        end
        if (en2 && r_v1) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        s_half  = DIFF_W'(r_wz) + DIFF_W'(r_xy);
        q_half  = DIFF_W'(r_yy) + DIFF_W'(r_zz);
        s_full  = ROT_W'(s_half) <<< 1;
        c_full  = ONE_Q28 - (ROT_W'(q_half) <<< 1);
        dx_full = ROT_W'(r_dx);
        dy_full = ROT_W'(r_dy);
        zero    = (s_full == '0) && (c_full == '0);

        n_data.bypass = zero;
        if (!zero && c_full[ROT_W-1]) begin
            n_data.c  = -c_full;
            n_data.s  = -s_full;
            n_data.dx = -dx_full;
            n_data.dy = -dy_full;
        end else begin
            n_data.c  = c_full;
            n_data.s  = s_full;
            n_data.dx = dx_full;
            n_data.dy = dy_full;
        end
    end

endmodule

@@ sv/pwb_cordic_cell.sv @@
// one vectoring micro-rotation applied to the yaw pair and the offset
module pwb_cordic_cell import pwb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_stage,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_rot             i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_rot             o_data
);

    logic                    r_valid;
    t_rot                    r_data;
    t_rot                    n_data;
    logic                    en;
    logic signed [ROT_W-1:0] c;
    logic signed [ROT_W-1:0] s;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] c_sh;
    logic signed [ROT_W-1:0] s_sh;
    logic signed [ROT_W-1:0] x_sh;
    logic signed [ROT_W-1:0] y_sh;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        c    = i_data.c;
        s    = i_data.s;
        x    = i_data.dx;
        y    = i_data.dy;
        c_sh = c >>> i_stage;
        s_sh = s >>> i_stage;
        x_sh = x >>> i_stage;
        y_sh = y >>> i_stage;
        n_data = i_data;
        if (!i_data.bypass) begin
            if (!s[ROT_W-1]) begin
                n_data.c  = c + s_sh;
                n_data.s  = s - c_sh;
                n_data.dx = x + y_sh;
                n_data.dy = y - x_sh;
            end else begin
                n_data.c  = c - s_sh;
                n_data.s  = s + c_sh;
                n_data.dx = x - y_sh;
                n_data.dy = y + x_sh;
            end
        end
    end

endmodule

@@ sv/pwb_gain.sv @@
// gain correction with split multiply, rounding and saturation to q16.16
module pwb_gain import pwb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_rot                      i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_local_x,
    output logic signed [COORD_W-1:0] o_local_y
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_SH - 1));
    localparam logic signed [SCL_W-1:0] SAT_MAX = SCL_W'(64'sd2147483647);
    localparam logic signed [SCL_W-1:0] SAT_MIN = SCL_W'(-64'sd2147483648);

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SCL_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = COORD_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = COORD_W'(SAT_MIN);
        end else begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      en1;
    logic                      en2;
    logic                      en3;
    logic signed [PLO_W-1:0]   r_xlo;
    logic signed [PLO_W-1:0]   r_ylo;
    logic signed [PHI_W-1:0]   r_xhi;
    logic signed [PHI_W-1:0]   r_yhi;
    logic signed [ROT_W-1:0]   r_dx;
    logic signed [ROT_W-1:0]   r_dy;
    logic                      r_bypass;
    logic signed [SCL_W-1:0]   r_sx;
    logic signed [SCL_W-1:0]   r_sy;
    logic signed [COORD_W-1:0] r_lx;
    logic signed [COORD_W-1:0] r_ly;
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   acc_y;
    logic signed [SCL_W-1:0]   n_sx;
    logic signed [SCL_W-1:0]   n_sy;

    assign en3       = !r_v3 || i_ready;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign o_ready   = en1;
    assign o_valid   = r_v3;
    assign o_local_x = r_lx;
    assign o_local_y = r_ly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // low half unsigned, high half signed
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_xlo    <= PLO_W'($signed({1'b0, i_data.dx[SPLIT_W-1:0]})) * PLO_W'(INV_GAIN);
            r_ylo    <= PLO_W'($signed({1'b0, i_data.dy[SPLIT_W-1:0]})) * PLO_W'(INV_GAIN);
            r_xhi    <= PHI_W'($signed(i_data.dx[ROT_W-1:SPLIT_W])) * PHI_W'(INV_GAIN);
            r_yhi    <= PHI_W'($signed(i_data.dy[ROT_W-1:SPLIT_W])) * PHI_W'(INV_GAIN);
            r_dx     <= i_data.dx;
            r_dy     <= i_data.dy;
            r_bypass <= i_data.bypass;
        end
        if (en2 && r_v1) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
        if (en3 && r_v2) begin
            r_lx <= sat32(r_sx);
            r_ly <= sat32(r_sy);
        end
    end

    always_comb begin
        acc_x = (ACC_W'(r_xhi) <<< SPLIT_W) + ACC_W'(r_xlo) + HALF;
        acc_y = (ACC_W'(r_yhi) <<< SPLIT_W) + ACC_W'(r_ylo) + HALF;
        if (r_bypass) begin
            n_sx = SCL_W'(r_dx);
            n_sy = SCL_W'(r_dy);
        end else begin
            n_sx = acc_x[ACC_W-1:FRAC_SH];
            n_sy = acc_y[ACC_W-1:FRAC_SH];
        end
    end

endmodule

@@ sv/pose_world_to_body_transform_core.sv @@
// top level: world point to robot body frame by quaternion yaw
// Takes one transaction per clock while the output is not stalled, and returns one
// result per transaction, in order. The offset and the yaw terms are registered in
// pwb_prep, each rotation cell has its own register, and pwb_gain registers the gain
// multiply, the rounding and the saturation in turn. Every stage has its own valid
// bit, so an output stall fills bubbles first and o_ready falls only when the whole
// pipeline is occupied. When both yaw terms are zero the offset passes unrotated.
module pose_world_to_body_transform_core import pwb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_robot_x,
    input  logic signed [COORD_W-1:0] i_robot_y,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_local_x,
    output logic signed [COORD_W-1:0] o_local_y
);

    t_rot             chain_data  [CORDIC_STAGES+1];
    logic             chain_valid [CORDIC_STAGES+1];
    logic             chain_ready [CORDIC_STAGES+1];
    logic [CNT_W-1:0] r_inflight;
    logic             in_acc;
    logic             out_acc;

    pwb_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_robot_x (i_robot_x),
        .i_robot_y (i_robot_y),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .o_valid   (chain_valid[0]),
        .i_ready   (chain_ready[0]),
        .o_data    (chain_data[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        pwb_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (IDX_W'(k)),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    pwb_gain u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[CORDIC_STAGES]),
        .o_ready   (chain_ready[CORDIC_STAGES]),
        .i_data    (chain_data[CORDIC_STAGES]),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_local_x (o_local_x),
        .o_local_y (o_local_y)
    );

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_acc && !out_acc) begin
            r_inflight <= r_inflight + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            r_inflight <= r_inflight - CNT_W'(1);
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_empty_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> !o_valid)
        else $error("result presented with nothing in flight");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage is empty");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == CNT_W'(PIPE_DEPTH)) && !i_ready |-> !o_ready)
        else $error("input accepted with pipeline full and output stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

@@ test/tb_pose_world_to_body_transform_core.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the world-to-body transform core with a fixed-point predictor
module tb_pose_world_to_body_transform_core;
    import pwb_pkg::*;

    localparam int NUM_RANDOM_POSES = 1800;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RECEIVER_HOLD    = 300;
    localparam int HOLD_AFTER       = 400;
    localparam int PAUSE_AT         = 1000;

    localparam int COORD_MAX = 2147483647;
    localparam int COORD_MIN = -2147483647 - 1;
    localparam int Q_ONE     = 16384;
    localparam int Q_HALF    = 8192;
    localparam int Q_SIN45   = 11585;
    localparam int METRE     = 65536;

    typedef struct {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] robot_x;
        logic signed [COORD_W-1:0] robot_y;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [QUAT_W-1:0]  quat_w;
    } t_pose_item;

    typedef struct {
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
        int                        index;
    } t_body_point;

    class t_body_frame_scoreboard;
        t_body_point body_points_due[$];
        longint      inv_gain_q30;
        int          poses_noted;
        int          results_checked;
        int          mismatches;

        function new();
            bit [63:0] g2;
            bit [63:0] lo;
            bit [63:0] hi;
            bit [63:0] mid;
            g2 = 64'd1 << 60;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                g2 += g2 >> (2 * i);
            end
            // floor square root by bisection, lo*lo <= g2 < hi*hi
            lo = 0;
            hi = 64'd1 << 32;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid <= g2) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            inv_gain_q30    = longint'((64'd1 << 60) / lo);
            poses_noted     = 0;
            results_checked = 0;
            mismatches      = 0;
        endfunction

        function logic signed [COORD_W-1:0] clamp_q16(longint v);
            if (v > longint'(COORD_MAX)) begin
                return COORD_MAX;
            end
            if (v < longint'(COORD_MIN)) begin
                return COORD_MIN;
            end
            return v[COORD_W-1:0];
        endfunction

        function t_body_point rotate_to_body(t_pose_item p);
            longint      dx, dy, c, s, nc, ns, nx, ny;
            longint      qx, qy, qz, qw;
            t_body_point r;
            dx = longint'(p.point_x) - longint'(p.robot_x);
            dy = longint'(p.point_y) - longint'(p.robot_y);
            qx = longint'(p.quat_x);
            qy = longint'(p.quat_y);
            qz = longint'(p.quat_z);
            qw = longint'(p.quat_w);
            s  = 2 * (qw * qz + qx * qy);
            c  = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
            r.index = 0;
            // yaw undefined: offset passes unrotated
            if (s == 0 && c == 0) begin
                r.local_x = clamp_q16(dx);
                r.local_y = clamp_q16(dy);
                return r;
            end
            if (c < 0) begin
                c  = -c;
                s  = -s;
                dx = -dx;
                dy = -dy;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (s >= 0) begin
                    nc = c + (s >>> i);
                    ns = s - (c >>> i);
                    nx = dx + (dy >>> i);
                    ny = dy - (dx >>> i);
                end else begin
                    nc = c - (s >>> i);
                    ns = s + (c >>> i);
                    nx = dx - (dy >>> i);
                    ny = dy + (dx >>> i);
                end
                c  = nc;
                s  = ns;
                dx = nx;
                dy = ny;
            end
            r.local_x = clamp_q16((dx * inv_gain_q30 + (longint'(1) <<< 29)) >>> 30);
            r.local_y = clamp_q16((dy * inv_gain_q30 + (longint'(1) <<< 29)) >>> 30);
            return r;
        endfunction

        task report(string what, int index, logic [31:0] got, logic [31:0] want);
            $display("mismatch: %s on transaction %0d: got %h, expected %h",
                     what, index, got, want);
            mismatches++;
        endtask

        function void note_input(t_pose_item p);
            t_body_point r;
            r       = rotate_to_body(p);
            r.index = poses_noted;
            poses_noted++;
            body_points_due.insert(body_points_due.size(), r);
        endfunction

        task check_result(logic signed [COORD_W-1:0] got_x, logic signed [COORD_W-1:0] got_y);
            t_body_point want;
            if (body_points_due.size() == 0) begin
                report("result with no transaction pending", results_checked, got_x, 0);
            end else begin
                want = body_points_due.pop_front();
                if (got_x !== want.local_x) begin
                    report("local_x", want.index, got_x, want.local_x);
                end
                if (got_y !== want.local_y) begin
                    report("local_y", want.index, got_y, want.local_y);
                end
            end
            results_checked++;
        endtask

        function int pending();
            return body_points_due.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic signed [COORD_W-1:0] i_robot_x;
    logic signed [COORD_W-1:0] i_robot_y;
    logic signed [QUAT_W-1:0]  i_quat_x;
    logic signed [QUAT_W-1:0]  i_quat_y;
    logic signed [QUAT_W-1:0]  i_quat_z;
    logic signed [QUAT_W-1:0]  i_quat_w;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [COORD_W-1:0] o_local_x;
    logic signed [COORD_W-1:0] o_local_y;

    t_body_frame_scoreboard sb = new();
    int                     idle_cycles = 0;

    pose_world_to_body_transform_core dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_pose_item make_pose(int px, int py, int rx, int ry,
                                             int qx, int qy, int qz, int qw);
        t_pose_item p;
        p.point_x = px;
        p.point_y = py;
        p.robot_x = rx;
        p.robot_y = ry;
        p.quat_x  = QUAT_W'(qx);
        p.quat_y  = QUAT_W'(qy);
        p.quat_z  = QUAT_W'(qz);
        p.quat_w  = QUAT_W'(qw);
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return int'($urandom_range(0, 200 * METRE)) - 100 * METRE;
        end
        if (pick < 75) begin
            return $urandom;
        end
        if (pick < 87) begin
            return COORD_MAX - int'($urandom_range(0, 65535));
        end
        return COORD_MIN + int'($urandom_range(0, 65535));
    endfunction

    function automatic t_pose_item random_pose();
        t_pose_item  p;
        int unsigned kind;
        real         a;
        real         norm;
        real         qr[4];
        int          q[4];
        int          sy;
        int          sz;
        p.point_x = random_coord();
        p.point_y = random_coord();
        p.robot_x = random_coord();
        p.robot_y = random_coord();
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // planar attitude, yaw only
            a    = ($urandom_range(0, 1000000) / 1000000.0 - 0.5) * 6.283185307179586;
            q[0] = 0;
            q[1] = 0;
            q[2] = int'(16384.0 * $sin(a / 2.0));
            q[3] = int'(16384.0 * $cos(a / 2.0));
            if ($urandom_range(0, 1) == 1) begin
                q[2] = -q[2];
                q[3] = -q[3];
            end
        end else if (kind < 65) begin
            foreach (q[k]) begin
                q[k] = int'($urandom_range(0, 32768)) - Q_ONE;
            end
        end else if (kind < 80) begin
            norm = 0.0;
            foreach (qr[k]) begin
                qr[k] = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
                norm += qr[k] * qr[k];
            end
            if (norm < 1.0e-6) begin
                norm = 1.0;
            end
            norm = $sqrt(norm);
            foreach (q[k]) begin
                q[k] = int'(16384.0 * qr[k] / norm);
            end
        end else if (kind < 90) begin
            // both yaw terms zero
            sy   = ($urandom_range(0, 1) == 1) ? Q_HALF : -Q_HALF;
            sz   = ($urandom_range(0, 1) == 1) ? Q_HALF : -Q_HALF;
            q[0] = int'($urandom_range(0, 32768)) - Q_ONE;
            q[1] = sy;
            q[2] = sz;
            q[3] = (sy == sz) ? -q[0] : q[0];
        end else begin
            foreach (q[k]) begin
                case ($urandom_range(0, 2))
                    0: q[k] = -Q_ONE;
                    1: q[k] = 0;
                    default: q[k] = Q_ONE;
                endcase
            end
        end
        p.quat_x = QUAT_W'(q[0]);
        p.quat_y = QUAT_W'(q[1]);
        p.quat_z = QUAT_W'(q[2]);
        p.quat_w = QUAT_W'(q[3]);
        return p;
    endfunction

    task automatic send_pose(input t_pose_item p, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= p.point_x;
        i_point_y <= p.point_y;
        i_robot_x <= p.robot_x;
        i_robot_y <= p.robot_y;
        i_quat_x  <= p.quat_x;
        i_quat_y  <= p.quat_y;
        i_quat_z  <= p.quat_z;
        i_quat_w  <= p.quat_w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    always @(posedge i_clk) begin : transaction_monitor
        t_pose_item seen;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen.point_x = i_point_x;
                seen.point_y = i_point_y;
                seen.robot_x = i_robot_x;
                seen.robot_y = i_robot_y;
                seen.quat_x  = i_quat_x;
                seen.quat_y  = i_quat_y;
                seen.quat_z  = i_quat_z;
                seen.quat_w  = i_quat_w;
                sb.note_input(seen);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_local_x, o_local_y);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int run;
        int stall;
        bit held;
        held = 1'b0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // long back-pressure so the pipeline fills and stalls its input
            if (!held && sb.results_checked >= HOLD_AFTER) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(posedge i_clk);
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_pose_item directed_poses[$];
        bit         burst;
        burst = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_point_x <= '0;
        i_point_y <= '0;
        i_robot_x <= '0;
        i_robot_y <= '0;
        i_quat_x  <= '0;
        i_quat_y  <= '0;
        i_quat_z  <= '0;
        i_quat_w  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_poses = {
            make_pose(0, 0, 0, 0, 0, 0, 0, Q_ONE),
            make_pose(0, 0, 0, 0, 0, 0, 0, 0),
            make_pose(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, 0, Q_ONE),
            make_pose(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 0, Q_ONE),
            make_pose(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0, Q_SIN45, Q_SIN45),
            make_pose(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, Q_HALF, Q_HALF, 0),
            make_pose(3 * METRE, -5 * METRE, METRE, 2 * METRE, 1000, Q_HALF, -Q_HALF, 1000),
            make_pose(-7 * METRE, 9 * METRE, 0, 0, -Q_ONE, -Q_HALF, -Q_HALF, Q_ONE),
            make_pose(10 * METRE, 4 * METRE, 0, 0, 0, 0, Q_ONE, 0),
            make_pose(METRE, 0, 0, 0, 0, 0, Q_SIN45, Q_SIN45),
            make_pose(0, METRE, 0, 0, 0, 0, -Q_SIN45, Q_SIN45),
            make_pose(5 * METRE, 7 * METRE, -2 * METRE, METRE, 0, Q_HALF, Q_HALF, Q_ONE),
            make_pose(5 * METRE, 7 * METRE, -2 * METRE, METRE, 0, Q_HALF, Q_HALF, -Q_ONE),
            make_pose(COORD_MAX, 0, 0, COORD_MIN, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE),
            make_pose(0, COORD_MIN, COORD_MAX, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE),
            make_pose(2 * METRE, 3 * METRE, 0, 0, Q_ONE, 0, 0, 0),
            make_pose(2 * METRE, 3 * METRE, 0, 0, -Q_ONE, 0, 0, 0),
            make_pose(123456, -654321, 0, 0, 1, 1, 1, 1),
            make_pose(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, Q_ONE, 0),
            make_pose(-1, -1, 0, 0, -1, -1, -1, -1)
        };
        foreach (directed_poses[k]) begin
            send_pose(directed_poses[k], pick_gap());
        end

        for (int n = 0; n < NUM_RANDOM_POSES; n++) begin
            if (n % 64 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            // let the pipeline drain completely once
            if (n == PAUSE_AT) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            send_pose(random_pose(), burst ? 0 : pick_gap());
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
